// ===== hw/rtl/despk_pkg.sv =====
// Shared types, constants and helper functions of the four-neighbor despeckle filter.
// Used by every module in hw/rtl except despk_ram; depends on nothing else.
`default_nettype none

package despk_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int PIXEL_BITS   = 8;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = 16;
    localparam int WIDTH_BITS   = 11;
    localparam int THR_BITS     = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 16;

    // Queue between front and back; depth is a power of two so pointers wrap.
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    // Result FIFO in front of the output ports; also a power of two.
    localparam int O_DEPTH    = 2;
    localparam int O_PTR_BITS = $clog2(O_DEPTH);
    localparam int O_CNT_BITS = $clog2(O_DEPTH + 1);

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = WIDTH_BITS'(30);
    localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = ROW_BITS'(20);
    localparam logic [THR_BITS-1:0]   THR_RESET    = THR_BITS'(1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_NOISE_THRESHOLD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] image_width;
        logic [ROW_BITS-1:0]   image_height;
        logic [THR_BITS-1:0]   noise_threshold;
    } cfg_t;

    // What the front decides about one accepted pixel.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic                  emit_prev;
        logic                  interior;
        logic                  last_row;
    } item_info_t;

    typedef struct packed {
        item_info_t            info;
        logic [PIXEL_BITS-1:0] cur;
        logic [PIXEL_BITS-1:0] rt;
    } q_entry_t;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [Q_CNT_BITS-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic second;
    } back_stat_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic                  last;
    } result_t;

    function automatic logic [PIXEL_BITS-1:0] abs_diff(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/despk_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependency.
`default_nettype none

module despk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/despk_front.sv =====
// Front end: takes pixels, tracks row and column, reads and updates the original line.
// Depends on despk_pkg and despk_ram.
`default_nettype none

module despk_front import despk_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  push,
    output logic                  full,
    input  logic [PIXEL_BITS-1:0] pixel_in,
    input  q_stat_t               q_stat,
    output logic                  q_push,
    output q_entry_t              q_data
);

    logic [COL_BITS-1:0]   col_reg, col_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic                  s1_valid_reg, s1_valid_next;
    item_info_t            info_reg, info_next;

    logic                  accept;
    logic [COL_BITS-1:0]   wm1;
    logic [ROW_BITS-1:0]   hm1;
    logic [COL_BITS-1:0]   col_use;
    logic [COL_BITS-1:0]   col_right;
    logic                  last_row;
    logic [PIXEL_BITS-1:0] cur_data;
    logic [PIXEL_BITS-1:0] rt_data;

    assign full   = s1_valid_reg && q_stat.full;
    assign accept = push && !full;
    assign q_push = s1_valid_reg && !q_stat.full;

    // Geometry in use: width saturates to 3..MAX_WIDTH, height is at least 3.
    always_comb
    begin
        if (cfg.image_width < WIDTH_BITS'(3))
        begin
            wm1 = COL_BITS'(2);
        end
        else if (int'(cfg.image_width) > MAX_WIDTH)
        begin
            wm1 = COL_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = COL_BITS'(cfg.image_width - WIDTH_BITS'(1));
        end

        if (cfg.image_height < ROW_BITS'(3))
        begin
            hm1 = ROW_BITS'(2);
        end
        else
        begin
            hm1 = cfg.image_height - ROW_BITS'(1);
        end
    end

    always_comb
    begin
        col_use   = (col_reg > wm1) ? wm1 : col_reg;
        col_right = col_use + COL_BITS'(1);
        last_row  = (row_reg >= hm1);

        info_next.pix       = pixel_in;
        info_next.row       = row_reg;
        info_next.col       = col_use;
        info_next.emit_prev = (row_reg != ROW_BITS'(0));
        info_next.interior  = (row_reg > ROW_BITS'(1)) && (col_use != COL_BITS'(0))
                              && (col_use < wm1);
        info_next.last_row  = last_row;

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_use == wm1)
            begin
                col_next = COL_BITS'(0);
                row_next = last_row ? ROW_BITS'(0) : (row_reg + ROW_BITS'(1));
            end
            else
            begin
                col_next = col_use + COL_BITS'(1);
            end
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            info_reg <= info_next;
        end
    end

    // The original line is kept twice so that the center and the right
    // neighbor can be read in the same cycle. Read data holds while stalled.
    despk_ram #(
        .WIDTH(PIXEL_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_orig_cur (
        .clk    (clk),
        .wr_en  (accept),
        .wr_addr(col_use),
        .wr_data(pixel_in),
        .rd_en  (accept),
        .rd_addr(col_use),
        .rd_data(cur_data)
    );

    despk_ram #(
        .WIDTH(PIXEL_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_orig_rt (
        .clk    (clk),
        .wr_en  (accept),
        .wr_addr(col_use),
        .wr_data(pixel_in),
        .rd_en  (accept),
        .rd_addr(col_right),
        .rd_data(rt_data)
    );

    assign q_data = '{info: info_reg, cur: cur_data, rt: rt_data};

endmodule

`default_nettype wire

// ===== hw/rtl/despk_queue.sv =====
// Short register queue that decouples the front end from the back end.
// Depends on despk_pkg.
`default_nettype none

module despk_queue import despk_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr,
    input  q_entry_t wr_data,
    input  logic     rd,
    output q_entry_t rd_data,
    output q_stat_t  stat
);

    q_entry_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0] count_reg, count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign stat.full  = (count_reg == Q_CNT_BITS'(Q_DEPTH));
    assign stat.empty = (count_reg == Q_CNT_BITS'(0));
    assign stat.count = count_reg;

    assign do_wr = wr && !stat.full;
    assign do_rd = rd && !stat.empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? (wr_ptr_reg + Q_PTR_BITS'(1)) : wr_ptr_reg;
        rd_ptr_next = do_rd ? (rd_ptr_reg + Q_PTR_BITS'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + Q_CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - Q_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== hw/rtl/despk_back.sv =====
// Back end: applies the four-neighbor test, keeps the filtered line and queues results.
// Depends on despk_pkg and despk_ram.
`default_nettype none

module despk_back import despk_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [THR_BITS-1:0]   thr,
    input  q_stat_t               q_stat,
    input  q_entry_t              q_head,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic [PIXEL_BITS-1:0] pixel_out,
    output logic [ROW_BITS-1:0]   out_row,
    output logic [COL_BITS-1:0]   out_col,
    output logic                  run_last,
    output back_stat_t            b_stat
);

    q_entry_t              st_reg;
    logic                  st_valid_reg, st_valid_next;
    logic                  phase_reg, phase_next;
    logic [PIXEL_BITS-1:0] left_reg, left_next;

    result_t               o_mem_reg [O_DEPTH];
    logic [O_PTR_BITS-1:0] o_wr_ptr_reg, o_wr_ptr_next;
    logic [O_PTR_BITS-1:0] o_rd_ptr_reg, o_rd_ptr_next;
    logic [O_CNT_BITS-1:0] o_count_reg, o_count_next;

    logic [PIXEL_BITS-1:0] up;
    logic [PIXEL_BITS+1:0] sum;
    logic [PIXEL_BITS-1:0] y;
    logic                  replace;
    logic                  want_a;
    logic                  want_b;
    logic                  res_valid;
    logic                  res_push;
    logic                  o_space;
    logic                  o_pop;
    logic                  done;
    logic                  ld;
    logic                  fwrite;
    result_t               res;

    assign o_pop   = pop && (o_count_reg != O_CNT_BITS'(0));
    assign o_space = (o_count_reg != O_CNT_BITS'(O_DEPTH)) || o_pop;

    always_comb
    begin
        sum = (PIXEL_BITS+2)'(left_reg) + (PIXEL_BITS+2)'(st_reg.rt)
              + (PIXEL_BITS+2)'(up) + (PIXEL_BITS+2)'(st_reg.info.pix);
        replace = st_reg.info.interior
                  && (abs_diff(st_reg.cur, left_reg) > thr)
                  && (abs_diff(st_reg.cur, st_reg.rt) > thr)
                  && (abs_diff(st_reg.cur, up) > thr)
                  && (abs_diff(st_reg.cur, st_reg.info.pix) > thr);
        y = replace ? sum[PIXEL_BITS+1:2] : st_reg.cur;

        // The pixel one row up comes first; on the last row the pixel itself
        // follows it as a second result.
        want_a    = !phase_reg && st_reg.info.emit_prev;
        want_b    = st_reg.info.last_row && (phase_reg || !st_reg.info.emit_prev);
        res_valid = st_valid_reg && (want_a || want_b);
        res_push  = res_valid && o_space;
        done      = st_valid_reg
                    && (!res_valid || (res_push && !(want_a && st_reg.info.last_row)));
        fwrite    = res_push && want_a;

        if (want_a)
        begin
            res.pix  = y;
            res.row  = st_reg.info.row - ROW_BITS'(1);
            res.col  = st_reg.info.col;
            res.last = !st_reg.info.last_row;
        end
        else
        begin
            res.pix  = st_reg.info.pix;
            res.row  = st_reg.info.row;
            res.col  = st_reg.info.col;
            res.last = 1'b1;
        end

        ld    = !st_valid_reg || done;
        q_pop = ld && !q_stat.empty;

        if (ld)
        begin
            st_valid_next = !q_stat.empty;
        end
        else
        begin
            st_valid_next = st_valid_reg;
        end

        if (done)
        begin
            phase_next = 1'b0;
        end
        else if (res_push && want_a && st_reg.info.last_row)
        begin
            phase_next = 1'b1;
        end
        else
        begin
            phase_next = phase_reg;
        end

        left_next = fwrite ? y : left_reg;

        o_wr_ptr_next = res_push ? (o_wr_ptr_reg + O_PTR_BITS'(1)) : o_wr_ptr_reg;
        o_rd_ptr_next = o_pop ? (o_rd_ptr_reg + O_PTR_BITS'(1)) : o_rd_ptr_reg;
        o_count_next  = o_count_reg;
        if (res_push && !o_pop)
        begin
            o_count_next = o_count_reg + O_CNT_BITS'(1);
        end
        else if (o_pop && !res_push)
        begin
            o_count_next = o_count_reg - O_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            left_reg     <= '0;
            o_wr_ptr_reg <= '0;
            o_rd_ptr_reg <= '0;
            o_count_reg  <= '0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            o_wr_ptr_reg <= o_wr_ptr_next;
            o_rd_ptr_reg <= o_rd_ptr_next;
            o_count_reg  <= o_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            st_reg <= q_head;
        end
        if (res_push)
        begin
            o_mem_reg[o_wr_ptr_reg] <= res;
        end
    end

    // The upper neighbor is read as the item enters the stage, so the read
    // data stays aligned with st_reg while the stage stalls.
    despk_ram #(
        .WIDTH(PIXEL_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_filt (
        .clk    (clk),
        .wr_en  (fwrite),
        .wr_addr(st_reg.info.col),
        .wr_data(y),
        .rd_en  (q_pop),
        .rd_addr(q_head.info.col),
        .rd_data(up)
    );

    assign empty     = (o_count_reg == O_CNT_BITS'(0));
    assign pixel_out = o_mem_reg[o_rd_ptr_reg].pix;
    assign out_row   = o_mem_reg[o_rd_ptr_reg].row;
    assign out_col   = o_mem_reg[o_rd_ptr_reg].col;
    assign run_last  = o_mem_reg[o_rd_ptr_reg].last;

    assign b_stat.busy   = st_valid_reg;
    assign b_stat.second = phase_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/four_neighbour_despeckle_top.sv =====
// The first result of an accepted pixel passes the front stage register, the queue, the back
// stage register and the result FIFO to reach the output; the second result of a last-row
// pixel follows it. Throughput: one pixel per cycle while nothing stalls; on the last row the
// back stage keeps each pixel for its two results, as one result is written per cycle.
// Reset clears counters, queues and configuration (width 30, height 20, threshold 1); the line
// memories are not cleared. Depends on despk_pkg, despk_front, despk_queue and despk_back.
`default_nettype none

module four_neighbour_despeckle_top import despk_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [PIXEL_BITS-1:0]   pixel_in,
    output logic                    empty,
    input  logic                    pop,
    output logic [PIXEL_BITS-1:0]   pixel_out,
    output logic [ROW_BITS-1:0]     out_row,
    output logic [COL_BITS-1:0]     out_col,
    output logic                    run_last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_DAT_BITS-1:0] cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    q_stat_t    q_stat;
    q_entry_t   q_wr_data;
    q_entry_t   q_head;
    logic       q_push;
    logic       q_pop;
    back_stat_t b_stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT:    cfg_next.image_height    = cfg_data[ROW_BITS-1:0];
                REG_NOISE_THRESHOLD: cfg_next.noise_threshold = cfg_data[THR_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width     <= WIDTH_RESET;
            cfg_reg.image_height    <= HEIGHT_RESET;
            cfg_reg.noise_threshold <= THR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    despk_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .full    (full),
        .pixel_in(pixel_in),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_data  (q_wr_data)
    );

    despk_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_push),
        .wr_data(q_wr_data),
        .rd     (q_pop),
        .rd_data(q_head),
        .stat   (q_stat)
    );

    despk_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .thr      (cfg_reg.noise_threshold),
        .q_stat   (q_stat),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .pixel_out(pixel_out),
        .out_row  (out_row),
        .out_col  (out_col),
        .run_last (run_last),
        .b_stat   (b_stat)
    );

    // The second result of a last-row pixel only exists while that pixel is in the stage.
    a_second_busy: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.second |-> b_stat.busy)
        else $error("second result pending with no item in the back stage");

    // The front may only push back on the source when the queue is really full.
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_stat.full)
        else $error("full raised while the queue has room");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= Q_CNT_BITS'(Q_DEPTH))
        else $error("queue count beyond its depth");

    // A pop from the queue only happens when the queue holds an item.
    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back stage loaded from an empty queue");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for four_neighbour_despeckle_top: streams pixel frames in raster order,
// predicts every filtered pixel in a scoreboard class and compares the popped results field by field.
// Depends on despk_pkg and the four_neighbour_despeckle_top RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import despk_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_PAUSE  = 8;
    localparam int unsigned RANDOM_ITEMS = 1200;

    // Three 3x3 frames: a bright speck, a dark speck, and a speck whose average truncates.
    localparam logic [PIXEL_BITS-1:0] DIRECTED_FRAMES [27] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
        8'd0,   8'd30,  8'd0,   8'd10,  8'd128, 8'd41,  8'd0,   8'd20,  8'd0
    };

    typedef enum int {STYLE_SPECKLED, STYLE_NOISE, STYLE_BINARY} image_style_t;

    class filtered_pixel_board;
        logic [PIXEL_BITS-1:0] orig_line [MAX_WIDTH];
        logic [PIXEL_BITS-1:0] filt_line [MAX_WIDTH];
        logic [PIXEL_BITS-1:0] left_filt;
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned thresh_reg;
        result_t awaited[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned replaced;

        function new();
            left_filt  = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            thresh_reg = THR_RESET;
            mismatches = 0;
            checked    = 0;
            replaced   = 0;
        endfunction

        function int unsigned pix_gap(int unsigned a, int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DAT_BITS-1:0] value);
            case (idx)
                REG_IMAGE_WIDTH:     width_reg  = value[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT:    height_reg = value[ROW_BITS-1:0];
                REG_NOISE_THRESHOLD: thresh_reg = value[THR_BITS-1:0];
                default: ;
            endcase
        endfunction

        function bit at_frame_start();
            return col_pos == 0 && row_pos == 0;
        endfunction

        // One accepted pixel releases the pixel above it, and on the last row also itself.
        function void take_pixel(logic [PIXEL_BITS-1:0] p);
            int unsigned w, h, c, r, cur, y, lf, rt, up, dn;
            bit last_row;
            result_t res;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            h = (height_reg < 3) ? 3 : height_reg;
            c = (col_pos >= w) ? w - 1 : col_pos;
            r = row_pos;
            last_row = (r >= h - 1);
            if (r > 0) begin
                cur = orig_line[c];
                y = cur;
                if (r > 1 && c > 0 && c < w - 1) begin
                    lf = left_filt;
                    rt = orig_line[c + 1];
                    up = filt_line[c];
                    dn = p;
                    if (pix_gap(cur, lf) > thresh_reg && pix_gap(cur, rt) > thresh_reg &&
                        pix_gap(cur, up) > thresh_reg && pix_gap(cur, dn) > thresh_reg) begin
                        y = (lf + rt + up + dn) >> 2;
                        replaced++;
                    end
                end
                filt_line[c] = PIXEL_BITS'(y);
                left_filt    = PIXEL_BITS'(y);
                res.pix  = PIXEL_BITS'(y);
                res.row  = ROW_BITS'(r - 1);
                res.col  = COL_BITS'(c);
                res.last = !last_row;
                awaited.push_back(res);
            end
            orig_line[c] = p;
            if (last_row) begin
                res.pix  = p;
                res.row  = ROW_BITS'(r);
                res.col  = COL_BITS'(c);
                res.last = 1'b1;
                awaited.push_back(res);
            end
            if (c >= w - 1) begin
                col_pos = 0;
                row_pos = last_row ? 0 : ((r + 1) & 16'hFFFF);
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void match_pixel(logic [PIXEL_BITS-1:0] pix, logic [ROW_BITS-1:0] row,
                                  logic [COL_BITS-1:0] col, logic last);
            result_t want;
            if (awaited.size() == 0) begin
                $error("unexpected result: pixel_out %0d out_row %0d out_col %0d run_last %0d",
                       pix, row, col, last);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (pix !== want.pix) begin
                $error("pixel_out: expected %0d, actual %0d", want.pix, pix);
                mismatches++;
            end
            if (row !== want.row) begin
                $error("out_row: expected %0d, actual %0d", want.row, row);
                mismatches++;
            end
            if (col !== want.col) begin
                $error("out_col: expected %0d, actual %0d", want.col, col);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("run_last: expected %0d, actual %0d", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic [PIXEL_BITS-1:0]   pixel_in;
    logic                    empty;
    logic                    pop;
    logic [PIXEL_BITS-1:0]   pixel_out;
    logic [ROW_BITS-1:0]     out_row;
    logic [COL_BITS-1:0]     out_col;
    logic                    run_last;
    logic                    cfg_valid;
    logic                    cfg_ready;
    cfg_reg_t                cfg_index;
    logic [CFG_DAT_BITS-1:0] cfg_data;

    filtered_pixel_board board = new();

    bit           send_idle = 1'b1;
    bit           take_idle = 1'b1;
    image_style_t image_style = STYLE_SPECKLED;
    int unsigned  background = 128;
    int unsigned  sent_total = 0;
    int unsigned  frames_done = 0;
    int unsigned  settings_used = 0;
    int unsigned  cycle_count = 0;

    four_neighbour_despeckle_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel_in  (pixel_in),
        .empty     (empty),
        .pop       (pop),
        .pixel_out (pixel_out),
        .out_row   (out_row),
        .out_col   (out_col),
        .run_last  (run_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles with %0d results outstanding",
                   cycle_count, board.awaited.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            board.match_pixel(pixel_out, out_row, out_col, run_last);
    end

    initial
    begin : result_taker
        int unsigned hold;
        hold = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold != 0)
                hold--;
            else if (take_idle && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 12);
            pop <= (hold == 0);
        end
    end

    function automatic logic [PIXEL_BITS-1:0] next_pixel();
        int v;
        case (image_style)
            STYLE_SPECKLED:
            begin
                if ($urandom_range(0, 4) == 0)
                    v = $urandom_range(0, 255);
                else
                    v = int'(background) + int'($urandom_range(0, 6)) - 3;
            end
            STYLE_NOISE:
                v = $urandom_range(0, 255);
            default:
                v = $urandom_range(0, 1) ? 255 : 0;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIXEL_BITS'(v);
    endfunction

    function automatic void pick_style();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 12)
            image_style = STYLE_SPECKLED;
        else if (roll < 17)
            image_style = STYLE_NOISE;
        else
            image_style = STYLE_BINARY;
        background = $urandom_range(0, 255);
    endfunction

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] value);
        if (send_idle && $urandom_range(0, 9) == 0)
        begin
            push <= 1'b0;
            pixel_in <= PIXEL_BITS'($urandom);
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        push <= 1'b1;
        pixel_in <= value;
        do @(posedge clk); while (full);
        board.take_pixel(value);
        sent_total++;
        @(negedge clk);
    endtask

    task automatic finish_frame();
        do send_pixel(next_pixel()); while (!board.at_frame_start());
        frames_done++;
    endtask

    // Holds the stream back until every awaited pixel has been popped, then waits out
    // DRAIN_PAUSE so that the pipeline clears as well.
    task automatic settle();
        push <= 1'b0;
        while (board.awaited.size() != 0) @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    // Leaves cfg_valid high so back-to-back writes keep it steady; the caller lowers it.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DAT_BITS-1:0] w, input logic [CFG_DAT_BITS-1:0] h,
                             input logic [CFG_DAT_BITS-1:0] t);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_NOISE_THRESHOLD, t);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        int unsigned w, h, t, base;
        push      = 1'b0;
        pixel_in  = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset geometry: two rows, then the height drops below its range mid-frame so the
        // current row becomes the last one.
        pick_style();
        image_style = STYLE_SPECKLED;
        repeat (2 * WIDTH_RESET) send_pixel(next_pixel());
        settle();
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        cfg_valid <= 1'b0;
        finish_frame();
        settle();

        // Width and height below range, zero threshold, hand-made specks.
        send_idle = 1'b0;
        take_idle = 1'b0;
        configure(16'd0, 16'd2, 16'd0);
        foreach (DIRECTED_FRAMES[k]) send_pixel(DIRECTED_FRAMES[k]);
        frames_done += 3;
        settle();

        // Widest line: upper data bits are dropped and the width saturates; the width then
        // shrinks inside the last row.
        send_idle = 1'b1;
        take_idle = 1'b1;
        configure(16'hFFFF, 16'd3, 16'd20);
        pick_style();
        image_style = STYLE_SPECKLED;
        repeat (2 * MAX_WIDTH) send_pixel(next_pixel());
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'd5);
        cfg_valid <= 1'b0;
        finish_frame();
        settle();

        // Tallest frame, cut short by a later height write.
        configure(16'd4, 16'hFFFF, 16'd8);
        pick_style();
        repeat (20) send_pixel(next_pixel());
        settle();
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        cfg_valid <= 1'b0;
        finish_frame();
        settle();

        base = sent_total;
        while (sent_total - base < RANDOM_ITEMS)
        begin
            if (sent_total - base > RANDOM_ITEMS * 3 / 4)
            begin
                send_idle = 1'b0;
                take_idle = 1'b0;
            end
            else
            begin
                send_idle = $urandom_range(0, 3) != 0;
                take_idle = $urandom_range(0, 3) != 0;
            end
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(3, 12);
            h = $urandom_range(3, 7);
            case ($urandom_range(0, 5))
                0:       t = 0;
                1:       t = 255;
                2:       t = 16'hFF00 | $urandom_range(0, 40);
                default: t = $urandom_range(0, 40);
            endcase
            configure(CFG_DAT_BITS'(w), CFG_DAT_BITS'(h), CFG_DAT_BITS'(t));
            pick_style();
            repeat ($urandom_range(1, 2)) finish_frame();
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, w * (h - 1))) send_pixel(next_pixel());
                settle();
                if ($urandom_range(0, 1))
                    write_reg(REG_IMAGE_WIDTH, CFG_DAT_BITS'($urandom_range(3, w)));
                else
                    write_reg(REG_IMAGE_HEIGHT, CFG_DAT_BITS'($urandom_range(1, h)));
                cfg_valid <= 1'b0;
                finish_frame();
            end
            settle();
        end

        $display("Run covered %0d pixels in %0d frames under %0d register settings.",
                 sent_total, frames_done, settings_used);
        $display("%0d results checked, %0d pixels replaced by their neighbor average.",
                 board.checked, board.replaced);
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
